### src/bnfa_pkg.sv
// ----------------------------------------------------------------------------
// bnfa_pkg
// Shared types and constants of the next-fit bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bnfa_pkg;

	localparam int NUM_IDS    = 1024;
	localparam int WORD_BITS  = 32;
	localparam int WORD_SHIFT = 5;
	localparam int MAP_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int ID_W       = $clog2(NUM_IDS);
	localparam int SCAN_W     = $clog2(MAP_WORDS + 1);
	localparam int REQ_ID_W   = 10;

	// identifiers that exist in the last bitmap word
	localparam int LAST_BITS = NUM_IDS - (MAP_WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NONE_FREE     = 2'd1,
		ST_OUT_OF_RANGE  = 2'd2,
		ST_NOT_ALLOCATED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_BAD_ID  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic                opcode;
		logic [REQ_ID_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic [REQ_ID_W-1:0] granted_id;
		status_t             status;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [ID_W-1:0] id;
	} cmd_t;

endpackage

### src/bitmap_next_fit_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_next_fit_id_allocator
// Next-fit identifier allocator over a used/free bitmap with a rotating
// search start.
//
//   channel   dir   handshake              payload
//   request   in    req_valid / req_stall  req : opcode, release_id
//   response  out   rsp_valid / rsp_stall  rsp : granted_id, status
//
// A release is handled at its pop in the back end; an allocate scans one
// bitmap word per cycle starting at the search start, over up to all MAP_WORDS
// words, plus a closing pass over the start word. Reset clears the bitmap and
// the search start at once. The command
// queue holds two requests, so requests keep entering while a response beat
// is stalled; req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module bitmap_next_fit_id_allocator import bnfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t pop_cmd;
	logic q_not_empty;

	bnfa_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	bnfa_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_not_empty)
	);

	bnfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### src/bnfa_front.sv
// ----------------------------------------------------------------------------
// bnfa_front
// Accepts request beats and sorts them into allocate, release and bad-id
// commands for the command queue.
// ----------------------------------------------------------------------------
module bnfa_front import bnfa_pkg::*; (
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic push,
	output cmd_t push_cmd,
	input  logic q_full
);

	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	always_comb begin
		push_cmd.id = ID_W'(req.release_id);
		if (req.opcode == OP_ALLOC) begin
			push_cmd.kind = CMD_ALLOC;
		end else if (32'(req.release_id) >= NUM_IDS) begin
			push_cmd.kind = CMD_BAD_ID;
		end else begin
			push_cmd.kind = CMD_RELEASE;
		end
	end

endmodule

### src/bnfa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bnfa_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bnfa_cmd_fifo import bnfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### src/bnfa_back.sv
// ----------------------------------------------------------------------------
// bnfa_back
// Holds the used bitmap and the search start, runs the word-at-a-time
// next-fit scan and the releases, and registers each result beat.
// ----------------------------------------------------------------------------
module bnfa_back import bnfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                  state_q;
	logic [SCAN_W-1:0]       step_q;
	logic [WIDX_W-1:0]       widx_q;
	logic [WIDX_W-1:0]       ss_word_q;
	logic [WORD_SHIFT-1:0]   ss_bit_q;
	logic [WORD_BITS-1:0]    map_q [MAP_WORDS];
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    out_free;
	logic [WIDX_W-1:0]       rel_word;
	logic [WORD_SHIFT-1:0]   rel_bit;
	logic [WIDX_W-1:0]       rd_idx;
	logic [WORD_BITS-1:0]    rd_word;
	logic                    first_step;
	logic                    last_step;
	logic [WORD_BITS-1:0]    lo_mask;
	logic [WORD_BITS-1:0]    win_mask;
	logic [WORD_BITS-1:0]    ids_mask;
	logic [WORD_BITS-1:0]    free_bits;
	logic                    hit;
	logic [WORD_SHIFT-1:0]   hit_bit;
	logic [WIDX_W+WORD_SHIFT-1:0] hit_id;
	logic [WIDX_W-1:0]       widx_next;
	logic                    rel_used;
	logic                    rsp_set;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rel_word  = WIDX_W'(cmd.id >> WORD_SHIFT);
	assign rel_bit   = cmd.id[WORD_SHIFT-1:0];
	assign rd_idx    = (state_q == S_SCAN) ? widx_q : rel_word;
	assign rd_word   = map_q[rd_idx];
	assign rel_used  = rd_word[rel_bit];

	// first word looks at bits from the start up, the closing pass at bits below
	assign first_step = step_q == '0;
	assign last_step  = step_q == SCAN_W'(MAP_WORDS);
	assign lo_mask    = {WORD_BITS{1'b1}} << ss_bit_q;
	assign win_mask   = first_step ? lo_mask : (last_step ? ~lo_mask : {WORD_BITS{1'b1}});
	assign ids_mask   = (widx_q == WIDX_W'(MAP_WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
	assign free_bits  = ~rd_word & win_mask & ids_mask;
	assign hit        = |free_bits;
	assign hit_id     = {widx_q, hit_bit};
	assign widx_next  = (widx_q == WIDX_W'(MAP_WORDS - 1)) ? '0 : widx_q + 1'b1;

	// a release or bad id answers at the pop, an allocate when the scan ends
	assign rsp_set = (cmd_pop && (cmd.kind != CMD_ALLOC)) ||
		((state_q == S_SCAN) && (hit || last_step));

	always_comb begin
		hit_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				hit_bit = WORD_SHIFT'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			widx_q      <= '0;
			ss_word_q   <= '0;
			ss_bit_q    <= '0;
			rsp_valid_q <= 1'b0;
			for (int w = 0; w < MAP_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else begin
			rsp_valid_q <= rsp_set || (rsp_valid_q && rsp_stall);
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							CMD_ALLOC: begin
								state_q <= S_SCAN;
								step_q  <= '0;
								widx_q  <= ss_word_q;
							end
							CMD_RELEASE: begin
								if (rel_used) begin
									map_q[rel_word][rel_bit] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						map_q[widx_q][hit_bit] <= 1'b1;
						state_q     <= S_IDLE;
						// advance the search start past the granted id, wrapping at the end
						if (hit_id == (WIDX_W + WORD_SHIFT)'(NUM_IDS - 1)) begin
							ss_word_q <= '0;
							ss_bit_q  <= '0;
						end else if (hit_bit == WORD_SHIFT'(WORD_BITS - 1)) begin
							ss_word_q <= widx_next;
							ss_bit_q  <= '0;
						end else begin
							ss_word_q <= widx_q;
							ss_bit_q  <= hit_bit + 1'b1;
						end
					end else if (last_step) begin
						state_q     <= S_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
						widx_q <= widx_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					rsp_q.granted_id <= '0;
					case (cmd.kind)
						CMD_RELEASE: rsp_q.status <= rel_used ? ST_OK : ST_NOT_ALLOCATED;
						default:     rsp_q.status <= ST_OUT_OF_RANGE;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					rsp_q.granted_id <= REQ_ID_W'(hit_id);
					rsp_q.status     <= ST_OK;
				end else if (last_step) begin
					rsp_q.granted_id <= '0;
					rsp_q.status     <= ST_NONE_FREE;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule

### src/bnfa_checker.sv
// ----------------------------------------------------------------------------
// bnfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bnfa_checker import bnfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// queue, back end and response register together hold at most this many
	localparam int MAX_OPEN = CMDQ_DEPTH + 2;

	logic [3:0] open_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req_valid && !req_stall;
	assign rsp_beat = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_beat && !rsp_beat) begin
			open_q <= open_q + 1'b1;
		end else if (rsp_beat && !req_beat) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != '0)
		else $error("response beat without an open request");

	a_bounded_open: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 4'(MAX_OPEN))
		else $error("more requests open than the allocator can hold");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.granted_id == '0)
		else $error("nonzero granted_id on a failed request");

endmodule

bind bitmap_next_fit_id_allocator bnfa_checker u_bnfa_checker (.*);
